>>> hw/rtl/line_rasterizer_assert.svh
// Assertion macros for the line rasterizer.
// LR_ASSERT checks a property on the rising clock edge, off while reset is held.
// LR_ASSERT_CLK checks a property on every rising clock edge.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define LR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("line_rasterizer assertion failed");
`define LR_ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("line_rasterizer assertion failed");
`else
`define LR_ASSERT(lbl, clk, rstn, prop)
`define LR_ASSERT_CLK(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/lr_pkg.sv
package lr_pkg;

	// coordinate bits actually used, 2..6
	localparam int COORD_BITS = 6;
	// fixed width of the coordinate ports
	localparam int PORT_W = 6;
	// decision term and move step, two's complement
	localparam int DT_W = COORD_BITS + 3;
	// step when the minor axis holds (2 * minor delta)
	localparam int SNM_W = COORD_BITS + 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0] coord_t;

	// one classified line, ready for the walker
	typedef struct packed {
		coord_t            major_pos;
		coord_t            major_end;
		coord_t            minor_pos;
		logic [DT_W-1:0]   decision;
		logic [SNM_W-1:0]  step_no_move;
		logic [DT_W-1:0]   step_move;
		logic              steep;
		logic              falling;
	} lr_setup_t;

endpackage

>>> hw/rtl/lr_front.sv
module lr_front
	import lr_pkg::*;
(
	input  logic [PORT_W-1:0] start_x,
	input  logic [PORT_W-1:0] start_y,
	input  logic [PORT_W-1:0] end_x,
	input  logic [PORT_W-1:0] end_y,
	output lr_setup_t         setup
);

	coord_t x1, y1, x2, y2;
	logic [COORD_BITS:0] dx, dy;
	coord_t adx, ady, dmaj, dmin;
	logic dx_pos, dx_neg, dy_pos, dy_neg, steep;

	assign x1 = start_x[COORD_BITS-1:0];
	assign y1 = start_y[COORD_BITS-1:0];
	assign x2 = end_x[COORD_BITS-1:0];
	assign y2 = end_y[COORD_BITS-1:0];

	assign dx = {1'b0, x2} - {1'b0, x1};
	assign dy = {1'b0, y2} - {1'b0, y1};

	assign dx_neg = dx[COORD_BITS];
	assign dy_neg = dy[COORD_BITS];
	assign dx_pos = !dx_neg && (dx != '0);
	assign dy_pos = !dy_neg && (dy != '0);

	// magnitude always fits in COORD_BITS
	assign adx = dx_neg ? coord_t'(-dx) : coord_t'(dx);
	assign ady = dy_neg ? coord_t'(-dy) : coord_t'(dy);

	assign steep = adx < ady;
	assign dmaj  = steep ? ady : adx;
	assign dmin  = steep ? adx : ady;

	always_comb begin
		setup.steep   = steep;
		setup.falling = (dx_pos && dy_neg) || (dx_neg && dy_pos);
		// walk starts from the endpoint with the smaller major coordinate
		if (!steep) begin
			setup.major_pos = dx_pos ? x1 : x2;
			setup.major_end = dx_pos ? x2 : x1;
			setup.minor_pos = dx_pos ? y1 : y2;
		end else begin
			setup.major_pos = dy_pos ? y1 : y2;
			setup.major_end = dy_pos ? y2 : y1;
			setup.minor_pos = dy_pos ? x1 : x2;
		end
		setup.step_no_move = {1'b0, dmin, 1'b0};
		setup.step_move    = {2'b00, dmin, 1'b0} - {2'b00, dmaj, 1'b0};
		setup.decision     = {2'b00, dmin, 1'b0} - {3'b000, dmaj};
	end

endmodule

>>> hw/rtl/lr_queue.sv
module lr_queue
	import lr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lr_setup_t push_data,
	output logic      full,
	input  logic      pop,
	output logic      not_empty,
	output lr_setup_t pop_data
);

	`include "line_rasterizer_assert.svh"

	lr_setup_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`LR_ASSERT(a_q_no_overflow, clk, arst_n, count_q <= QCNT_W'(QUEUE_DEPTH))
	`LR_ASSERT(a_q_pop_nonempty, clk, arst_n, pop |-> not_empty)
	`LR_ASSERT(a_q_push_not_full, clk, arst_n, push |-> !full || pop)

endmodule

>>> hw/rtl/lr_walker.sv
module lr_walker
	import lr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  lr_setup_t         q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PORT_W-1:0] pixel_x,
	output logic [PORT_W-1:0] pixel_y,
	output logic              last_pixel
);

	`include "line_rasterizer_assert.svh"

	logic              active_q;
	coord_t            maj_q, end_q, min_q;
	logic [DT_W-1:0]   dec_q, sm_q;
	logic [SNM_W-1:0]  snm_q;
	logic              steep_q, fall_q;

	logic out_xfer, last;

	assign last      = maj_q == end_q;
	assign out_valid = active_q;
	assign out_xfer  = active_q && !out_stall;
	// load the next line when idle, or as the last pixel leaves
	assign q_pop     = q_valid && (!active_q || (out_xfer && last));

	assign pixel_x    = PORT_W'(steep_q ? min_q : maj_q);
	assign pixel_y    = PORT_W'(steep_q ? maj_q : min_q);
	assign last_pixel = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (q_pop) begin
			active_q <= 1'b1;
		end else if (out_xfer && last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			maj_q   <= q_data.major_pos;
			end_q   <= q_data.major_end;
			min_q   <= q_data.minor_pos;
			dec_q   <= q_data.decision;
			snm_q   <= q_data.step_no_move;
			sm_q    <= q_data.step_move;
			steep_q <= q_data.steep;
			fall_q  <= q_data.falling;
		end else if (out_xfer && !last) begin
			maj_q <= maj_q + 1'b1;
			if (dec_q[DT_W-1]) begin
				dec_q <= dec_q + {1'b0, snm_q};
			end else begin
				min_q <= fall_q ? min_q - 1'b1 : min_q + 1'b1;
				dec_q <= dec_q + sm_q;
			end
		end
	end

	`LR_ASSERT(a_w_stay_busy, clk, arst_n, (out_xfer && !last) |=> active_q)
	`LR_ASSERT(a_w_major_step, clk, arst_n,
		(out_xfer && !last) |=> maj_q == coord_t'($past(maj_q) + 1'b1))
	`LR_ASSERT(a_w_pop_when_free, clk, arst_n, q_pop |-> (!active_q || last))

endmodule

>>> hw/rtl/line_rasterizer.sv
// A line request is written into the queue, then loaded into the walker registers,
//   which offer its first pixel.
// Each line gives |major delta| + 1 pixels (1 to 64), one pixel per cycle while out_stall
//   is low, set by the walker's single step unit; a queued next line follows with no gap.
// Reset: arst_n, asynchronous active low, empties the queue and idles the walker.
module line_rasterizer
	import lr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// line requests
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PORT_W-1:0] start_x,
	input  logic [PORT_W-1:0] start_y,
	input  logic [PORT_W-1:0] end_x,
	input  logic [PORT_W-1:0] end_y,
	// pixels
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PORT_W-1:0] pixel_x,
	output logic [PORT_W-1:0] pixel_y,
	output logic              last_pixel
);

	// Front: classify the request (steep or shallow, rising or falling),
	// pick the start endpoint and build the Bresenham steps, all in the
	// transfer cycle. The result lands directly in the queue.
	lr_setup_t front_setup;
	lr_setup_t q_head;
	logic      q_full, q_not_empty, q_pop, push;

	// the front stalls only on a full queue
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	lr_front u_front (
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.setup   (front_setup)
	);

	// Two-entry queue decouples request intake from pixel output, so a
	// new line can be taken while the walker is still busy or stalled.
	lr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_setup),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_head)
	);

	// Back: walks the major axis one pixel per transfer. Its registers hold
	// the pixel on offer, so a stalled pixel simply stays put.
	lr_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_data     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

endmodule
